// File: rtl/prt_pkg.sv
// Shared constants, codes and controller/datapath handshake structures of the route table.
`timescale 1ns / 1ps

package prt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;

    localparam int OP_W   = 2;
    localparam int ADDR_W = 32;
    localparam int POS_W  = 4;
    localparam int STAT_W = 3;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic KIND_DIRECT = 1'b0;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_PROTECTED = 3'd2,
        ST_NO_ENTRY  = 3'd3,
        ST_NO_ROUTE  = 3'd4
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    idx_pos;
        logic    idx_inc;
        logic    insert;
        logic    remove;
        logic    emit;
        t_status status;
        logic    hop_sel;
        logic    pos_idx;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            kind;
        logic            full;
        logic            scan_end;
        logic            add_hit;
        logic            lk_hit;
        logic            idx_absent;
        logic            rd_kind;
        logic            out_free;
    } t_stat;

endpackage

// File: rtl/prt_if.sv
// Request and response channel interfaces of the route table.
`timescale 1ns / 1ps

interface prt_req_if;
    import prt_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] prefix_mask;
    logic [ADDR_W-1:0] gateway;
    logic              route_kind;
    logic [POS_W-1:0]  position;

    modport source (output valid, op, address, prefix_mask, gateway, route_kind, position,
                    input ready);
    modport sink   (input valid, op, address, prefix_mask, gateway, route_kind, position,
                    output ready);
endinterface

interface prt_rsp_if;
    import prt_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] next_hop;
    logic [POS_W-1:0]  entry_position;

    modport source (output valid, status, next_hop, entry_position, input ready);
    modport sink   (input valid, status, next_hop, entry_position, output ready);
endinterface

// File: rtl/prt_ctrl.sv
// Controller state machine that sequences add, remove and lookup requests.
`timescale 1ns / 1ps

module prt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  prt_pkg::t_stat i_stat,
    output prt_pkg::t_cmd  o_cmd
);
    import prt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_ADD,
        S_SCAN_LK,
        S_CHECK_RM
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    OP_ADD: begin
                        if (i_stat.full) begin
                            if (i_stat.out_free) begin
                                o_cmd.emit   = 1'b1;
                                o_cmd.status = ST_FULL;
                                n_state      = S_IDLE;
                            end
                        end else if (i_stat.kind == KIND_DIRECT) begin
                            // The index was cleared on load, so a direct route goes to the front.
                            if (i_stat.out_free) begin
                                o_cmd.insert  = 1'b1;
                                o_cmd.emit    = 1'b1;
                                o_cmd.pos_idx = 1'b1;
                                n_state       = S_IDLE;
                            end
                        end else begin
                            n_state = S_SCAN_ADD;
                        end
                    end
                    OP_REMOVE: begin
                        o_cmd.idx_pos = 1'b1;
                        n_state       = S_CHECK_RM;
                    end
                    OP_LOOKUP: begin
                        n_state = S_SCAN_LK;
                    end
                    default: begin
                        if (i_stat.out_free) begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_NO_ENTRY;
                            n_state      = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN_ADD: begin
                if (i_stat.scan_end || i_stat.add_hit) begin
                    if (i_stat.out_free) begin
                        o_cmd.insert  = 1'b1;
                        o_cmd.emit    = 1'b1;
                        o_cmd.pos_idx = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_SCAN_LK: begin
                if (i_stat.scan_end) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_NO_ROUTE;
                        n_state      = S_IDLE;
                    end
                end else if (i_stat.lk_hit) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.hop_sel = 1'b1;
                        o_cmd.pos_idx = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_CHECK_RM: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.pos_idx = 1'b1;
                    n_state       = S_IDLE;
                    if (i_stat.idx_absent) begin
                        o_cmd.status = ST_NO_ENTRY;
                    end else if (i_stat.rd_kind == KIND_DIRECT) begin
                        o_cmd.status = ST_PROTECTED;
                    end else begin
                        o_cmd.remove = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/prt_dp.sv
// Datapath: route entries, scan index, entry count and the response register.
`timescale 1ns / 1ps

module prt_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [prt_pkg::OP_W-1:0]   i_op,
    input  logic [prt_pkg::ADDR_W-1:0] i_address,
    input  logic [prt_pkg::ADDR_W-1:0] i_prefix_mask,
    input  logic [prt_pkg::ADDR_W-1:0] i_gateway,
    input  logic                    i_route_kind,
    input  logic [prt_pkg::POS_W-1:0]  i_position,
    input  prt_pkg::t_cmd           i_cmd,
    output prt_pkg::t_stat          o_stat,
    output logic                    o_rsp_valid,
    input  logic                    i_rsp_ready,
    output logic [prt_pkg::STAT_W-1:0] o_status,
    output logic [prt_pkg::ADDR_W-1:0] o_next_hop,
    output logic [prt_pkg::POS_W-1:0]  o_entry_position
);
    import prt_pkg::*;

    // Captured request.
    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_address;
    logic [ADDR_W-1:0] r_mask_in;
    logic [ADDR_W-1:0] r_gateway;
    logic              r_kind_in;
    logic [POS_W-1:0]  r_position;

    // Route entries.
    logic [ADDR_W-1:0] r_mask [TABLE_ENTRIES];
    logic [ADDR_W-1:0] r_net  [TABLE_ENTRIES];
    logic [ADDR_W-1:0] r_hop  [TABLE_ENTRIES];
    logic              r_kind [TABLE_ENTRIES];

    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;

    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [ADDR_W-1:0] r_next_hop;
    logic [POS_W-1:0]  r_entry_pos;

    logic [IDX_W-1:0]  idx_lo;
    logic [ADDR_W-1:0] rd_mask, rd_net, rd_hop;
    logic              rd_kind;
    logic              out_free;

    assign idx_lo  = r_idx[IDX_W-1:0];
    assign rd_mask = r_mask[idx_lo];
    assign rd_net  = r_net[idx_lo];
    assign rd_hop  = r_hop[idx_lo];
    assign rd_kind = r_kind[idx_lo];
    assign out_free = !r_out_valid || i_rsp_ready;

    always_comb begin
        o_stat.op         = r_op;
        o_stat.kind       = r_kind_in;
        o_stat.full       = (r_count >= CNT_W'(TABLE_ENTRIES));
        o_stat.scan_end   = (r_idx == r_count);
        o_stat.add_hit    = (rd_kind != KIND_DIRECT) && (rd_mask <= r_mask_in);
        o_stat.lk_hit     = ((rd_mask & r_address) == rd_net);
        o_stat.idx_absent = (r_idx >= r_count);
        o_stat.rd_kind    = rd_kind;
        o_stat.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_op;
            r_address  <= i_address;
            r_mask_in  <= i_prefix_mask;
            r_gateway  <= i_gateway;
            r_kind_in  <= i_route_kind;
            r_position <= i_position;
        end
    end

    // Each entry behind the index takes its new value from its neighbour, so an insert or a
    // remove moves the whole tail together.
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_ent
        localparam int PREV = (g > 0) ? g - 1 : 0;
        localparam int NEXT = (g < TABLE_ENTRIES - 1) ? g + 1 : g;

        always_ff @(posedge i_clk) begin
            if (i_cmd.insert) begin
                if (IDX_W'(g) == idx_lo) begin
                    r_mask[g] <= r_mask_in;
                    r_net[g]  <= r_address;
                    r_hop[g]  <= r_gateway;
                    r_kind[g] <= r_kind_in;
                end else if (IDX_W'(g) > idx_lo) begin
                    r_mask[g] <= r_mask[PREV];
                    r_net[g]  <= r_net[PREV];
                    r_hop[g]  <= r_hop[PREV];
                    r_kind[g] <= r_kind[PREV];
                end
            end else if (i_cmd.remove) begin
                if (g < TABLE_ENTRIES - 1 && IDX_W'(g) >= idx_lo) begin
                    r_mask[g] <= r_mask[NEXT];
                    r_net[g]  <= r_net[NEXT];
                    r_hop[g]  <= r_hop[NEXT];
                    r_kind[g] <= r_kind[NEXT];
                end
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.remove) begin
            n_count = r_count - CNT_W'(1);
        end

        n_idx = r_idx;
        if (i_cmd.load) begin
            n_idx = '0;
        end else if (i_cmd.idx_pos) begin
            n_idx = CNT_W'(r_position);
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + CNT_W'(1);
        end

        n_out_valid = r_out_valid;
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status    <= i_cmd.status;
            r_next_hop  <= i_cmd.hop_sel ? rd_hop : '0;
            r_entry_pos <= i_cmd.pos_idx ? POS_W'(r_idx) : '0;
        end
    end

    assign o_rsp_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_next_hop       = r_next_hop;
    assign o_entry_position = r_entry_pos;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count exceeds table size");

    a_insert_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> (!o_stat.full && r_idx <= r_count))
        else $error("insert into a full table or beyond the last entry");

    a_remove_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.remove |-> (!o_stat.idx_absent && rd_kind != KIND_DIRECT))
        else $error("remove of an absent or protected entry");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("response overwritten before it was taken");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_cmd.insert && !i_cmd.remove) |=> $stable(r_count))
        else $error("entry count changed without an insert or remove");

endmodule

// File: rtl/prefix_ordered_route_table_top.sv
// Top level of the ordered route table: controller and datapath behind request channels.
// One request at a time. A direct add, a full add or an unused code is answered from the
// dispatch state, a remove after the index is set to its position, and a lookup or static
// add when a scan stops at a hit or at entry_count; no answer is made while the previous
// response is untaken. A new request is accepted the cycle after the answer, even while
// it waits. Synchronous active-low reset empties the table; entry contents are not cleared.
`timescale 1ns / 1ps

module prefix_ordered_route_table_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    prt_req_if.sink   i_req,
    prt_rsp_if.source o_rsp
);
    import prt_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  req_ready;

    assign i_req.ready = req_ready;

    prt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    prt_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (i_req.op),
        .i_address        (i_req.address),
        .i_prefix_mask    (i_req.prefix_mask),
        .i_gateway        (i_req.gateway),
        .i_route_kind     (i_req.route_kind),
        .i_position       (i_req.position),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_rsp_valid      (o_rsp.valid),
        .i_rsp_ready      (o_rsp.ready),
        .o_status         (o_rsp.status),
        .o_next_hop       (o_rsp.next_hop),
        .o_entry_position (o_rsp.entry_position)
    );

endmodule
